### sv/mlm_pkg.sv
// mlm_pkg: shared constants, types and helpers of the masked 3x3 local maximum unit
// no dependencies; imported by the interfaces, the line buffer, the peak judge and the top

package mlm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int VALUE_W    = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] WIDTH_LIMIT      = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_LIMIT     = DIM_W'(MAX_HEIGHT);

  typedef logic [COL_W-1:0] col_addr_t;
  typedef logic [ROW_W-1:0] row_idx_t;
  typedef logic signed [VALUE_W-1:0] sample_t;

  // center line entry: sample with its highlight bit
  typedef struct packed {
    logic    mask;
    sample_t value;
  } center_t;

  // one column of the 3x3 window, rows top to bottom
  typedef struct packed {
    sample_t top;
    center_t mid;
    sample_t bot;
  } win_col_t;

  // which neighbors of the center lie inside the image
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nb_valid_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### sv/mlm_in_if.sv
// mlm_in_if: input item channel (pixel samples and pad items)
// depends on mlm_pkg for the sample type

interface mlm_in_if;
  import mlm_pkg::*;

  logic    valid;
  logic    ready;
  logic    cmd;
  sample_t sample_value;
  logic    highlight;

  modport source (output valid, cmd, sample_value, highlight, input ready);
  modport sink   (input valid, cmd, sample_value, highlight, output ready);
endinterface

### sv/mlm_out_if.sv
// mlm_out_if: result item channel (one decision slot per input item)
// depends on mlm_pkg for row, column and sample types

interface mlm_out_if;
  import mlm_pkg::*;

  logic      valid;
  logic      ready;
  logic      decided;
  logic      is_peak;
  row_idx_t  pixel_row;
  col_addr_t pixel_col;
  sample_t   peak_value;
  logic      frame_last;

  modport source (output valid, decided, is_peak, pixel_row, pixel_col, peak_value,
                  frame_last, input ready);
  modport sink   (input valid, decided, is_peak, pixel_row, pixel_col, peak_value,
                  frame_last, output ready);
endinterface

### sv/masked_local_maximum_3x3_unit.sv
// masked_local_maximum_3x3_unit: streamed masked 3x3 local maximum detector, top level
// depends on mlm_pkg, mlm_in_if, mlm_out_if, mlm_line_buf and mlm_peak_judge
//
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | cmd, sample_value, highlight
//  out_ch   | out | valid/ready        | decided, is_peak, pixel_row, pixel_col,
//           |     |                    | peak_value, frame_last
//  cfg_*    | in  | cfg_wr_en, no wait | cfg_index, cfg_data
//
// one item per cycle while out_ch takes results. the stage-1 register takes the item as the
// line memory is read; the output register then takes its result from the window compare.
// a pixel's decision rides on the item that arrives frame_width+1 items later.
// reset clears counters, window and handshake state; the line memories are not cleared.
// when out_ch stalls with a result waiting the whole pipe holds and in_ch.ready drops;
// otherwise in_ch.ready stays high and items pass back to back.

module masked_local_maximum_3x3_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  mlm_in_if.sink                         in_ch,
  mlm_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [mlm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlm_pkg::DIM_W-1:0]      cfg_data
);
  import mlm_pkg::*;

  typedef struct packed {
    logic      counted;
    logic      decided;
    logic      last;
    logic      byp;
    col_addr_t col;
    row_idx_t  dec_row;
    col_addr_t dec_col;
    nb_valid_t nb;
    center_t   pix;
  } s1_t;

  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [DIM_W-1:0] in_row_r, in_row_nxt;
  col_addr_t        in_col_r, in_col_nxt;
  logic [DIM_W-1:0] pre_cnt_r, pre_cnt_nxt;
  row_idx_t         dec_row_r, dec_row_nxt;
  col_addr_t        dec_col_r, dec_col_nxt;

  s1_t      s1_r, s1_nxt;
  logic     s1_valid_r;
  sample_t  byp_above_r;
  center_t  byp_center_r;
  win_col_t win_c_r, win_l_r;
  win_col_t trip;

  logic      out_valid_r, out_decided_r, out_peak_r, out_last_r;
  row_idx_t  out_row_r;
  col_addr_t out_col_r;
  sample_t   out_value_r;

  logic             advance, in_accept;
  logic [DIM_W-1:0] wm1, wp1, hm1;
  logic             pixel_phase, counted_in, decided_in, last_in, byp_in;
  logic             judge_peak;
  sample_t          rd_above;
  center_t          rd_center;

  assign advance   = !out_valid_r || out_ch.ready;
  assign in_accept = in_ch.valid && advance;
  assign in_ch.ready = advance;

  assign wm1 = frame_width_r - DIM_W'(1);
  assign wp1 = frame_width_r + DIM_W'(1);
  assign hm1 = frame_height_r - DIM_W'(1);

  // a pad while pixels are still due is dropped; in the flush every item counts
  assign pixel_phase = in_row_r < frame_height_r;
  assign counted_in  = !(pixel_phase && in_ch.cmd);
  assign decided_in  = pre_cnt_r == wp1;
  assign last_in     = decided_in && (dec_row_r == hm1[ROW_W-1:0])
                       && (dec_col_r == wm1[COL_W-1:0]);
  // with a one-pixel row, or across a frame boundary, an item reads the column
  // its predecessor writes
  assign byp_in      = s1_valid_r && s1_r.counted && counted_in && (in_col_r == s1_r.col);

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    pre_cnt_nxt = pre_cnt_r;
    dec_row_nxt = dec_row_r;
    dec_col_nxt = dec_col_r;
    if (in_accept && counted_in) begin
      if (in_col_r == wm1[COL_W-1:0]) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + DIM_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (!decided_in) begin
        pre_cnt_nxt = pre_cnt_r + DIM_W'(1);
      end else if (dec_col_r == wm1[COL_W-1:0]) begin
        dec_col_nxt = '0;
        dec_row_nxt = dec_row_r + ROW_W'(1);
      end else begin
        dec_col_nxt = dec_col_r + COL_W'(1);
      end
      if (last_in) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        pre_cnt_nxt = '0;
        dec_row_nxt = '0;
        dec_col_nxt = '0;
      end
    end
  end

  always_comb begin
    s1_nxt.counted   = counted_in;
    s1_nxt.decided   = counted_in && decided_in;
    s1_nxt.last      = counted_in && last_in;
    s1_nxt.byp       = byp_in;
    s1_nxt.col       = in_col_r;
    s1_nxt.dec_row   = dec_row_r;
    s1_nxt.dec_col   = dec_col_r;
    s1_nxt.nb.up     = dec_row_r != '0;
    s1_nxt.nb.down   = dec_row_r != hm1[ROW_W-1:0];
    s1_nxt.nb.left   = dec_col_r != '0;
    s1_nxt.nb.right  = dec_col_r != wm1[COL_W-1:0];
    s1_nxt.pix.mask  = in_ch.highlight;
    s1_nxt.pix.value = in_ch.sample_value;
  end

  // newest window column: two rows from the line memories, current row from the item
  always_comb begin
    trip.top = s1_r.byp ? byp_above_r  : rd_above;
    trip.mid = s1_r.byp ? byp_center_r : rd_center;
    trip.bot = s1_r.pix.value;
  end

  mlm_line_buf u_line_buf (
    .clk       (clk),
    .rd_en     (in_accept && counted_in),
    .rd_addr   (in_col_r),
    .wr_en     (advance && s1_valid_r && s1_r.counted),
    .wr_addr   (s1_r.col),
    .wr_above  (trip.mid.value),
    .wr_center (s1_r.pix),
    .rd_above  (rd_above),
    .rd_center (rd_center)
  );

  mlm_peak_judge u_peak_judge (
    .left_col   (win_l_r),
    .center_col (win_c_r),
    .right_col  (trip),
    .nb         (s1_r.nb),
    .is_peak    (judge_peak)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      in_row_r       <= '0;
      in_col_r       <= '0;
      pre_cnt_r      <= '0;
      dec_row_r      <= '0;
      dec_col_r      <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      win_c_r        <= '0;
      win_l_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          frame_width_r <= clamp_dim(cfg_data, WIDTH_LIMIT);
        end else begin
          frame_height_r <= clamp_dim(cfg_data, HEIGHT_LIMIT);
        end
        // any write restarts the frame
        in_row_r  <= '0;
        in_col_r  <= '0;
        pre_cnt_r <= '0;
        dec_row_r <= '0;
        dec_col_r <= '0;
      end else begin
        in_row_r  <= in_row_nxt;
        in_col_r  <= in_col_nxt;
        pre_cnt_r <= pre_cnt_nxt;
        dec_row_r <= dec_row_nxt;
        dec_col_r <= dec_col_nxt;
      end
      if (advance) begin
        s1_valid_r  <= in_ch.valid;
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r && s1_r.counted) begin
        win_l_r <= win_c_r;
        win_c_r <= trip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
    if (in_accept && byp_in) begin
      byp_above_r  <= trip.mid.value;
      byp_center_r <= s1_r.pix;
    end
    if (advance && s1_valid_r) begin
      out_decided_r <= s1_r.decided;
      out_peak_r    <= s1_r.decided && judge_peak;
      out_row_r     <= s1_r.decided ? s1_r.dec_row : '0;
      out_col_r     <= s1_r.decided ? s1_r.dec_col : '0;
      out_value_r   <= s1_r.decided ? win_c_r.mid.value : '0;
      out_last_r    <= s1_r.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.decided    = out_decided_r;
  assign out_ch.is_peak    = out_peak_r;
  assign out_ch.pixel_row  = out_row_r;
  assign out_ch.pixel_col  = out_col_r;
  assign out_ch.peak_value = out_value_r;
  assign out_ch.frame_last = out_last_r;

`ifndef NO_ASSERTIONS
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= frame_height_r + DIM_W'(1))
    else $error("input row counter ran past the flush rows");

  a_pre_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pre_cnt_r <= wp1)
    else $error("decision delay counter ran past frame_width+1");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_decided_r |-> !out_peak_r && !out_last_r && out_value_r == '0)
    else $error("undecided result carries a decision field");
`endif
endmodule

### sv/mlm_line_buf.sv
// mlm_line_buf: the two line memories (row above, center row with mask) indexed by column
// depends on mlm_pkg; one read and one write per cycle, read data registered

module mlm_line_buf (
  input  logic               clk,
  input  logic               rd_en,
  input  mlm_pkg::col_addr_t rd_addr,
  input  logic               wr_en,
  input  mlm_pkg::col_addr_t wr_addr,
  input  mlm_pkg::sample_t   wr_above,
  input  mlm_pkg::center_t   wr_center,
  output mlm_pkg::sample_t   rd_above,
  output mlm_pkg::center_t   rd_center
);
  import mlm_pkg::*;

  sample_t above_mem  [MAX_WIDTH];
  center_t center_mem [MAX_WIDTH];

  sample_t rd_above_r;
  center_t rd_center_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr]  <= wr_above;
      center_mem[wr_addr] <= wr_center;
    end
  end

  // read returns the old contents on a same-address write; the top forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_above_r  <= above_mem[rd_addr];
      rd_center_r <= center_mem[rd_addr];
    end
  end

  assign rd_above  = rd_above_r;
  assign rd_center = rd_center_r;
endmodule

### sv/mlm_peak_judge.sv
// mlm_peak_judge: 3x3 compare of the center against its in-image neighbors
// depends on mlm_pkg for the window column and neighbor flag types

module mlm_peak_judge (
  input  mlm_pkg::win_col_t  left_col,
  input  mlm_pkg::win_col_t  center_col,
  input  mlm_pkg::win_col_t  right_col,
  input  mlm_pkg::nb_valid_t nb,
  output logic               is_peak
);
  import mlm_pkg::*;

  sample_t c;
  logic    beaten;

  assign c = center_col.mid.value;

  // ties do not beat the center
  always_comb begin
    beaten = 1'b0;
    if (nb.up   && center_col.top > c) beaten = 1'b1;
    if (nb.down && center_col.bot > c) beaten = 1'b1;
    if (nb.left) begin
      if (left_col.mid.value > c)         beaten = 1'b1;
      if (nb.up   && left_col.top > c)    beaten = 1'b1;
      if (nb.down && left_col.bot > c)    beaten = 1'b1;
    end
    if (nb.right) begin
      if (right_col.mid.value > c)        beaten = 1'b1;
      if (nb.up   && right_col.top > c)   beaten = 1'b1;
      if (nb.down && right_col.bot > c)   beaten = 1'b1;
    end
  end

  assign is_peak = center_col.mid.mask && !beaten;
endmodule

### dv/tb_masked_local_maximum_3x3_unit.sv
`timescale 1ns / 100ps
// tb_masked_local_maximum_3x3_unit: self-checking bench for the masked 3x3 peak detector
// depends on mlm_pkg, mlm_in_if, mlm_out_if and masked_local_maximum_3x3_unit

module tb_masked_local_maximum_3x3_unit;
  import mlm_pkg::*;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_PAD   = 1'b1;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   RANDOM_ITEMS  = 950;
  localparam int   CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic      decided;
    logic      is_peak;
    row_idx_t  row;
    col_addr_t col;
    sample_t   value;
    logic      last;
  } decision_t;

  // tracks the pixel stream and works out the decision each item carries
  class peak_tracker;
    localparam int RING = 2 * MAX_WIDTH + 3;
    sample_t     ring_val[RING];
    logic        ring_hl[RING];
    int          width_px  = 640;
    int          height_px = 480;
    int          count     = 0;
    int          faults    = 0;
    decision_t   due_decisions[$];

    function int clamp_size(logic [DIM_W-1:0] v, int hi);
      if (v == '0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_px = clamp_size(data, MAX_WIDTH);
      else height_px = clamp_size(data, MAX_HEIGHT);
      count = 0;
    endfunction

    // masked and no in-image neighbor strictly greater
    function logic judge_center(int p);
      int      r;
      int      c;
      sample_t mid;
      r   = p / width_px;
      c   = p % width_px;
      mid = ring_val[p % RING];
      if (!ring_hl[p % RING]) return 1'b0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (r + dr < 0 || r + dr >= height_px || c + dc < 0 || c + dc >= width_px) continue;
          if (ring_val[((r + dr) * width_px + c + dc) % RING] > mid) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void take_sample(logic cmd, sample_t v, logic hl);
      int        total;
      int        p;
      decision_t d;
      total = width_px * height_px;
      d = '0;
      if (count < total) begin
        // stray pad while pixels are still due
        if (cmd == CMD_PAD) begin
          due_decisions = {due_decisions, d};
          return;
        end
        ring_val[count % RING] = v;
        ring_hl[count % RING]  = hl;
      end
      count++;
      if (count >= width_px + 2) begin
        p = count - (width_px + 2);
        if (p < total) begin
          d.decided = 1'b1;
          d.is_peak = judge_center(p);
          d.row     = row_idx_t'(p / width_px);
          d.col     = col_addr_t'(p % width_px);
          d.value   = ring_val[p % RING];
          if (p == total - 1) begin
            d.last = 1'b1;
            count  = 0;
          end
        end
      end
      due_decisions = {due_decisions, d};
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        faults++;
      end
    endfunction

    function void match_decision(decision_t got);
      decision_t want;
      if (due_decisions.size() == 0) begin
        $display("%0t: unexpected decision, expected none actual %p", $time, got);
        faults++;
        return;
      end
      want = due_decisions.pop_front();
      flag("decided", want.decided, got.decided);
      flag("is_peak", want.is_peak, got.is_peak);
      flag("pixel_row", want.row, got.row);
      flag("pixel_col", want.col, got.col);
      flag("peak_value", 32'(want.value), 32'(got.value));
      flag("frame_last", want.last, got.last);
    endfunction

    function int pending();
      return due_decisions.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  bit                   calm = 1'b0;
  int                   data_mode = 0;
  int                   counted_items = 0;
  int                   cycles = 0;
  peak_tracker          tracker = new();

  mlm_in_if  in_ch ();
  mlm_out_if out_ch ();

  masked_local_maximum_3x3_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.take_sample(in_ch.cmd, in_ch.sample_value, in_ch.highlight);
      if (out_ch.valid && out_ch.ready)
        tracker.match_decision({out_ch.decided, out_ch.is_peak, out_ch.pixel_row,
                                out_ch.pixel_col, out_ch.peak_value, out_ch.frame_last});
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_masked_local_maximum_3x3_unit failed");
        $finish;
      end
    end
  end

  function automatic sample_t pick_sample();
    case (data_mode)
      0: return sample_t'($urandom_range(3));
      1: return sample_t'($urandom);
      default: return sample_t'(int'($urandom_range(4)) - 2);
    endcase
  endfunction

  // valid stays high after acceptance; the next call or settle() decides its level
  task automatic push_item(input logic cmd, input sample_t v, input logic hl);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.sample_value <= v;
    in_ch.highlight    <= hl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic reconfigure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // npix pixels with a few stray pads, then the flush when asked
  task automatic feed_frame(input int npix, input bit flush);
    int sent;
    sent = 0;
    while (sent < npix) begin
      if ($urandom_range(99) < 4) begin
        push_item(CMD_PAD, pick_sample(), 1'($urandom));
      end else begin
        push_item(CMD_PIXEL, pick_sample(), $urandom_range(99) < 75);
        sent++;
        counted_items++;
      end
    end
    if (flush) begin
      for (int k = 0; k <= tracker.width_px; k++) begin
        push_item(($urandom_range(99) < 10) ? CMD_PIXEL : CMD_PAD, pick_sample(),
                  1'($urandom));
        counted_items++;
      end
    end
  endtask

  initial begin
    int base;
    int w;
    int h;
    int frames;
    int r;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = REG_FRAME_WIDTH;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_PIXEL;
    in_ch.sample_value = '0;
    in_ch.highlight    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x3 frame: corners, edges, center, extreme values and ties
    reconfigure(11'd3, 11'd3);
    push_item(CMD_PAD, 16'sh1234, 1'b1);
    push_item(CMD_PIXEL, 16'sh7fff, 1'b1);
    push_item(CMD_PIXEL, 16'sh7fff, 1'b1);
    push_item(CMD_PIXEL, -16'sh8000, 1'b1);
    push_item(CMD_PIXEL, -16'sh8000, 1'b0);
    push_item(CMD_PIXEL, 16'sh0005, 1'b1);
    push_item(CMD_PIXEL, 16'sh0005, 1'b1);
    push_item(CMD_PIXEL, 16'sh0000, 1'b1);
    push_item(CMD_PIXEL, -16'sh0001, 1'b1);
    push_item(CMD_PIXEL, 16'sh7fff, 1'b0);
    push_item(CMD_PAD, 16'sh0000, 1'b0);
    // pixel during the flush: its sample is dropped
    push_item(CMD_PIXEL, 16'sh7fff, 1'b1);
    push_item(CMD_PAD, 16'sh0000, 1'b0);
    push_item(CMD_PAD, 16'sh0000, 1'b0);

    // zero sizes clamp to a single pixel frame
    reconfigure(11'd0, 11'd0);
    push_item(CMD_PIXEL, -16'sh0001, 1'b1);
    push_item(CMD_PAD, 16'sh0000, 1'b0);
    push_item(CMD_PAD, 16'sh0000, 1'b0);
    push_item(CMD_PIXEL, -16'sh8000, 1'b0);
    push_item(CMD_PAD, 16'sh0000, 1'b0);
    push_item(CMD_PAD, 16'sh0000, 1'b0);

    // one column, oversize height clamps; the frame is cut after 64 rows
    reconfigure(11'd1, 11'd2047);
    data_mode = 2;
    feed_frame(64, 1'b0);

    base = counted_items;
    while (counted_items - base < RANDOM_ITEMS) begin
      calm = (counted_items - base >= 350) && (counted_items - base < 700);
      r = $urandom_range(99);
      if (r < 80) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
      end else if (r < 97) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 12);
      end else begin
        w = 0;
        h = 0;
      end
      reconfigure(DIM_W'(w), DIM_W'(h));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        data_mode = $urandom_range(2);
        if (f == frames - 1 && $urandom_range(99) < 20)
          feed_frame($urandom_range(0, tracker.width_px * tracker.height_px - 1), 1'b0);
        else
          feed_frame(tracker.width_px * tracker.height_px, 1'b1);
      end
    end
    calm = 1'b0;

    settle();
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("tb_masked_local_maximum_3x3_unit passed");
    end else begin
      $display("tb_masked_local_maximum_3x3_unit failed");
    end
    $finish;
  end

endmodule

### masked_local_maximum_3x3_unit.f
sv/mlm_pkg.sv
sv/mlm_in_if.sv
sv/mlm_out_if.sv
sv/mlm_line_buf.sv
sv/mlm_peak_judge.sv
sv/masked_local_maximum_3x3_unit.sv
dv/tb_masked_local_maximum_3x3_unit.sv
